>>> rtl/pcvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcvd_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 64;
	localparam int COUNT_W = 31;
	localparam int TYPE_W  = 3;
	localparam int BEAT_W  = 4;   // width of the per-byte beat count: up to eight values plus a status

	// value_type codes
	localparam logic [TYPE_W-1:0] TYPE_INT32   = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_INT64   = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_BYTES   = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_BOOL    = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_FLOAT32 = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_FLOAT64 = 3'd5;

	// configuration register indexes
	localparam logic REG_VALUE_TYPE  = 1'b0;
	localparam logic REG_VALUE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		KIND_FIXED  = 2'd0,
		KIND_SBYTE  = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word_shift;
		logic [2:0]         byte_position;
		logic [COUNT_W-1:0] values_done;
		logic [COUNT_W-1:0] string_remaining;
		logic               in_payload;
		logic               halted;
	} dec_state_t;

	// Results caused by one input byte: nmain value beats, then optionally a status beat.
	typedef struct packed {
		logic [BEAT_W-1:0] nmain;
		logic              is_bool;
		kind_t             kind;
		logic [WORD_W-1:0] value;
		logic              slast;
		logic              has_status;
		logic              ok;
	} bundle_t;

endpackage

`default_nettype wire

>>> rtl/plain_column_value_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Plain column value decoder.
// Input stream (s_axis): one page data byte per beat, tlast on the final byte of the
// chunk. Output stream (m_axis): decoded values; tuser gives the result kind (fixed
// value, string byte, empty string, final status), tlast marks the last byte of a
// byte array, tdata carries the raw value and the success flag of a status beat.
// value_type and value_count are set through the cfg write port while idle.
// Input bytes land in a two-entry skid queue, so s_axis_tready is a registered signal.
// The decoder takes one byte per cycle from the queue whenever the output register is
// free, and loads its results into the output register.
// Throughput: one byte per cycle when each byte makes at most one result. A byte
// makes up to nine beats (eight booleans plus a status on tlast); the output register
// drains one beat per cycle and the queue holds further bytes meanwhile.
// Bytes that only gather part of a word or length produce no beat.
// m_axis_tready low freezes the output beat; input keeps flowing until the queue fills.
// Reset clears registers, decode state, skid queue and output valid; no clearing pass.
// After each status beat the decode state starts afresh; registers are kept.
module plain_column_value_decoder import pcvd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [COUNT_W-1:0] cfg_data,
	// input beats
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  wire logic               s_axis_tlast,   // chunk_end
	// output beats
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [71:0]             m_axis_tdata,   // [63:0] value, [64] success, zero pad
	output logic                    m_axis_tlast,   // string_last
	output logic [1:0]              m_axis_tuser    // [1:0] kind
);

	// configuration registers
	logic [TYPE_W-1:0]  value_type_q;
	logic [COUNT_W-1:0] value_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_type_q  <= '0;
			value_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VALUE_TYPE:  value_type_q  <= cfg_data[TYPE_W-1:0];
				REG_VALUE_COUNT: value_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// two-entry skid queue on the input
	logic [1:0]        q_cnt_q;
	logic [BYTE_W-1:0] q_byte0_q, q_byte1_q;
	logic              q_end0_q, q_end1_q;
	logic              push, pop;
	logic [1:0]        wr_slot;

	// output register state
	logic              b_valid_q;
	bundle_t           b_q;
	logic [BEAT_W-1:0] idx_q;
	logic [BEAT_W-1:0] total;
	logic              main_beat, last_beat, b_free;

	assign s_axis_tready = (q_cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = (q_cnt_q != 2'd0) && b_free;
	assign wr_slot       = q_cnt_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
		end else begin
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_cnt_q == 2'd2) begin
			q_byte0_q <= q_byte1_q;
			q_end0_q  <= q_end1_q;
		end
		if (push && wr_slot == 2'd0) begin
			q_byte0_q <= s_axis_tdata;
			q_end0_q  <= s_axis_tlast;
		end else if (push && wr_slot == 2'd1) begin
			q_byte1_q <= s_axis_tdata;
			q_end1_q  <= s_axis_tlast;
		end
	end

	// decode the head byte against the running state
	dec_state_t st_q, st_next;
	bundle_t    b_next;

	pcvd_decode u_decode (
		.cfg_type  (value_type_q),
		.cfg_count (value_count_q),
		.data_byte (q_byte0_q),
		.chunk_end (q_end0_q),
		.cur       (st_q),
		.nxt       (st_next),
		.bnd       (b_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (pop) begin
			st_q <= st_next;
		end
	end

	// output register: drains the bundle one beat per cycle while m_axis_tready is high
	assign total     = b_q.nmain + BEAT_W'(b_q.has_status);
	assign last_beat = (idx_q + BEAT_W'(1)) == total;
	assign b_free    = !b_valid_q || (m_axis_tready && last_beat);
	assign main_beat = idx_q < b_q.nmain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_q <= 1'b0;
			idx_q     <= '0;
		end else if (b_free) begin
			b_valid_q <= pop && (b_next.nmain != '0 || b_next.has_status);
			idx_q     <= '0;
		end else if (m_axis_tready) begin
			idx_q <= idx_q + BEAT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (b_free && pop) begin
			b_q <= b_next;
		end
	end

	// booleans come LSB first out of the stored byte
	always_comb begin
		m_axis_tvalid = b_valid_q;
		m_axis_tdata  = '0;
		m_axis_tlast  = 1'b0;
		m_axis_tuser  = KIND_STATUS;
		if (main_beat) begin
			m_axis_tuser = b_q.kind;
			m_axis_tlast = b_q.slast;
			if (b_q.is_bool) begin
				m_axis_tdata[0] = b_q.value[idx_q[2:0]];
			end else begin
				m_axis_tdata[WORD_W-1:0] = b_q.value;
			end
		end else begin
			m_axis_tdata[WORD_W] = b_q.ok;
		end
	end

	// checks
	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid_q |-> total != '0)
		else $error("output bundle holds no beat");

	a_single_unless_bool: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid_q && !b_q.is_bool |-> b_q.nmain <= BEAT_W'(1))
		else $error("several value beats from a non-boolean byte");

	a_payload_owed: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.in_payload |-> st_q.string_remaining != '0)
		else $error("string payload active with nothing owed");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && st_q.halted |-> b_next.nmain == '0)
		else $error("value produced after decoding stopped");

endmodule

`default_nettype wire

>>> rtl/pcvd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module pcvd_decode import pcvd_pkg::*; (
	input  wire logic [TYPE_W-1:0]  cfg_type,
	input  wire logic [COUNT_W-1:0] cfg_count,
	input  wire logic [BYTE_W-1:0]  data_byte,
	input  wire logic               chunk_end,
	input  wire dec_state_t         cur,
	output dec_state_t              nxt,
	output bundle_t                 bnd
);

	logic [WORD_W-1:0]  sh;
	logic [2:0]         pos_inc;
	logic               active;
	logic [COUNT_W-1:0] left;
	logic [BEAT_W-1:0]  cnt;
	logic [COUNT_W-1:0] rem_dec;
	logic [31:0]        len;

	always_comb begin
		sh      = cur.word_shift | (WORD_W'(data_byte) << {cur.byte_position, 3'b000});
		pos_inc = cur.byte_position + 3'd1;
		active  = !cur.halted && (cur.values_done < cfg_count);
		left    = cfg_count - cur.values_done;
		cnt     = (left < COUNT_W'(8)) ? left[BEAT_W-1:0] : BEAT_W'(8);
		rem_dec = cur.string_remaining - COUNT_W'(1);
		len     = sh[31:0];

		nxt = cur;
		bnd = '0;
		bnd.kind = KIND_FIXED;

		if (active) begin
			unique case (cfg_type) inside
				TYPE_INT32, TYPE_FLOAT32: begin
					if (cur.byte_position >= 3'd3) begin
						bnd.nmain         = BEAT_W'(1);
						bnd.value         = {32'b0, sh[31:0]};
						nxt.word_shift    = '0;
						nxt.byte_position = '0;
						nxt.values_done   = cur.values_done + COUNT_W'(1);
					end else begin
						nxt.word_shift    = sh;
						nxt.byte_position = pos_inc;
					end
				end
				TYPE_INT64, TYPE_FLOAT64: begin
					if (cur.byte_position == 3'd7) begin
						bnd.nmain         = BEAT_W'(1);
						bnd.value         = sh;
						nxt.word_shift    = '0;
						nxt.byte_position = '0;
						nxt.values_done   = cur.values_done + COUNT_W'(1);
					end else begin
						nxt.word_shift    = sh;
						nxt.byte_position = pos_inc;
					end
				end
				TYPE_BYTES: begin
					if (cur.in_payload) begin
						nxt.string_remaining = rem_dec;
						bnd.nmain            = BEAT_W'(1);
						bnd.kind             = KIND_SBYTE;
						bnd.value            = WORD_W'(data_byte);
						bnd.slast            = (rem_dec == '0);
						if (rem_dec == '0) begin
							nxt.in_payload  = 1'b0;
							nxt.values_done = cur.values_done + COUNT_W'(1);
						end
					end else if (cur.byte_position >= 3'd3) begin
						nxt.word_shift    = '0;
						nxt.byte_position = '0;
						if (len[31]) begin
							nxt.halted = 1'b1;
						end else if (len == 32'd0) begin
							bnd.nmain       = BEAT_W'(1);
							bnd.kind        = KIND_EMPTY;
							nxt.values_done = cur.values_done + COUNT_W'(1);
						end else begin
							nxt.string_remaining = len[COUNT_W-1:0];
							nxt.in_payload       = 1'b1;
						end
					end else begin
						nxt.word_shift    = sh;
						nxt.byte_position = pos_inc;
					end
				end
				TYPE_BOOL: begin
					bnd.nmain       = cnt;
					bnd.is_bool     = 1'b1;
					bnd.value       = WORD_W'(data_byte);
					nxt.values_done = cur.values_done + COUNT_W'(cnt);
				end
				default: begin
				end
			endcase
		end

		if (chunk_end) begin
			bnd.has_status = 1'b1;
			bnd.ok         = (cfg_type <= TYPE_FLOAT64) && !nxt.halted &&
			                 (nxt.values_done == cfg_count);
			nxt            = '0;
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_plain_column_value_decoder.sv
`timescale 1ns / 1ps

module tb_plain_column_value_decoder import pcvd_pkg::*; ();

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 180;
	localparam int SETTLE_CYCLES = 10;    // covers the skid queue plus output register
	localparam int MAX_IDLE      = 16;
	localparam int LONG_HOLD     = 300;   // long receiver stall to back up the input
	localparam int CYCLE_LIMIT   = 400000;

	// value_type codes the block does not decode
	localparam logic [TYPE_W-1:0] TYPE_RSVD6 = 3'd6;
	localparam logic [TYPE_W-1:0] TYPE_RSVD7 = 3'd7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// one output beat as the monitor sees it
	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] value;
		logic              slast;
		logic              ok;
	} dec_result_t;

	// one row of the directed table: a register write or an input byte,
	// optionally with the last beat it causes typed in by hand
	typedef struct packed {
		logic               is_cfg;
		logic               idx;
		logic [COUNT_W-1:0] cdata;
		logic [7:0]         db;
		logic               eoc;
		logic               typed;
		dec_result_t        want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = 1'b0;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [71:0]        m_axis_tdata;
	logic               m_axis_tlast;
	logic [1:0]         m_axis_tuser;

	always #(CLK_PERIOD / 2) clk = ~clk;

	plain_column_value_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
		.s_axis_tlast  (s_axis_tlast),   // chunk_end
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [63:0] value, [64] success, zero pad
		.m_axis_tlast  (m_axis_tlast),   // string_last
		.m_axis_tuser  (m_axis_tuser)    // [1:0] kind
	);

	// ------------------------------------------------------------------
	// Decoder model state: registers plus the per-chunk decode state.
	// ------------------------------------------------------------------
	logic [TYPE_W-1:0]  mdl_type = TYPE_INT32;
	logic [COUNT_W-1:0] mdl_count = '0;
	logic [WORD_W-1:0]  acc_word = '0;     // little-endian word being gathered
	logic [2:0]         acc_pos = '0;      // bytes of it so far
	logic [COUNT_W-1:0] done_cnt = '0;     // values completed in this chunk
	logic [COUNT_W-1:0] str_left = '0;     // payload bytes still owed
	logic               in_str = 1'b0;
	logic               stopped = 1'b0;    // negative length seen

	dec_result_t expected_beats[$];
	stim_row_t   rows[$];

	// bench bookkeeping
	int   errors = 0;
	int   beats_seen = 0;
	int   items_sent = 0;
	int   hold_item = -1;     // input beat number that triggers the long stall
	int   stall_left = 0;
	int   cycle_count = 0;
	logic quiet = 1'b0;       // no idling on either side while set
	logic hold_req = 1'b0;
	logic beat_taken = 1'b0;
	dec_result_t got_want;

	function automatic dec_result_t beat_of(kind_t k, logic [WORD_W-1:0] v, logic sl,
			logic ok);
		dec_result_t r;
		r.kind  = k;
		r.value = v;
		r.slast = sl;
		r.ok    = ok;
		return r;
	endfunction

	function automatic int idle_draw();
		return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
	endfunction

	// append one beat to the expected queue
	task automatic expect_beat(input dec_result_t r);
		expected_beats.insert(expected_beats.size(), r);
	endtask

	// append one row to the directed table
	task automatic add_row(input stim_row_t r);
		rows.insert(rows.size(), r);
	endtask

	task automatic clear_decode();
		acc_word = '0;
		acc_pos  = '0;
		done_cnt = '0;
		str_left = '0;
		in_str   = 1'b0;
		stopped  = 1'b0;
	endtask

	// add a byte to the word; full once nbytes are in
	task automatic gather_byte(input logic [7:0] db, input int nbytes, output logic full);
		acc_word = acc_word | ({56'd0, db} << (8 * acc_pos));
		if (int'(acc_pos) + 1 >= nbytes) begin
			acc_pos = '0;
			full = 1'b1;
		end else begin
			acc_pos = acc_pos + 3'd1;
			full = 1'b0;
		end
	endtask

	// queue every beat one input byte should produce
	task automatic decode_byte(input logic [7:0] db, input logic eoc);
		logic               full;
		logic [31:0]        len;
		logic [COUNT_W-1:0] left;
		logic [COUNT_W-1:0] cnt;
		logic               ok;
		if (!stopped && done_cnt < mdl_count) begin
			case (mdl_type)
				TYPE_INT32, TYPE_FLOAT32: begin
					gather_byte(db, 4, full);
					if (full) begin
						expect_beat(beat_of(KIND_FIXED, {32'd0, acc_word[31:0]},
							1'b0, 1'b0));
						acc_word = '0;
						done_cnt = done_cnt + 1'b1;
					end
				end
				TYPE_INT64, TYPE_FLOAT64: begin
					gather_byte(db, 8, full);
					if (full) begin
						expect_beat(beat_of(KIND_FIXED, acc_word, 1'b0, 1'b0));
						acc_word = '0;
						done_cnt = done_cnt + 1'b1;
					end
				end
				TYPE_BYTES: begin
					if (in_str) begin
						str_left = str_left - 1'b1;
						expect_beat(beat_of(KIND_SBYTE, {56'd0, db},
							str_left == '0, 1'b0));
						if (str_left == '0) begin
							in_str = 1'b0;
							done_cnt = done_cnt + 1'b1;
						end
					end else begin
						gather_byte(db, 4, full);
						if (full) begin
							len = acc_word[31:0];
							acc_word = '0;
							if (len[31]) begin
								stopped = 1'b1;
							end else if (len == '0) begin
								expect_beat(beat_of(KIND_EMPTY, '0, 1'b0, 1'b0));
								done_cnt = done_cnt + 1'b1;
							end else begin
								str_left = len[COUNT_W-1:0];
								in_str = 1'b1;
							end
						end
					end
				end
				TYPE_BOOL: begin
					// LSB first, stop at the configured count
					left = mdl_count - done_cnt;
					cnt = (left < 8) ? left : COUNT_W'(8);
					for (int i = 0; i < int'(cnt); i++)
						expect_beat(beat_of(KIND_FIXED, {63'd0, db[i]}, 1'b0, 1'b0));
					done_cnt = done_cnt + cnt;
				end
				default: ;
			endcase
		end
		if (eoc) begin
			ok = (mdl_type <= TYPE_FLOAT64) && !stopped && (done_cnt == mdl_count);
			expect_beat(beat_of(KIND_STATUS, '0, 1'b0, ok));
			clear_decode();
		end
	endtask

	// ------------------------------------------------------------------
	// Driving side. Inputs move on the falling edge, handshakes are
	// judged on the rising edge.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] db, input logic eoc, input logic typed,
			input dec_result_t want);
		int gap;
		gap = idle_draw();
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = db;
		s_axis_tlast  = eoc;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(db, eoc);
		// a hand-typed expectation replaces the model's last beat for this byte
		if (typed)
			expected_beats[expected_beats.size() - 1] = want;
		items_sent++;
		if (items_sent == hold_item)
			hold_req = 1'b1;
	endtask

	// stop offering, wait for every queued beat, then let leftovers in the
	// skid queue (bytes that make no beat) work through
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only called once drained
	task automatic cfg_write(input logic idx, input logic [COUNT_W-1:0] d);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		if (idx == REG_VALUE_TYPE)
			mdl_type = d[TYPE_W-1:0];
		else
			mdl_count = d;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiving side. A fresh stall is drawn after every beat taken; a
	// hold request from the sender forces one long stall.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			beat_taken = 1'b0;
			stall_left = LONG_HOLD;
		end else if (beat_taken) begin
			beat_taken = 1'b0;
			stall_left = idle_draw();
		end
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		errors++;
		$display("mismatch at output beat %0d: %s got %h expected %h",
			beats_seen, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beat_taken = 1'b1;
			if (expected_beats.size() == 0) begin
				flag_mismatch("beat with nothing expected", m_axis_tdata[WORD_W-1:0], '0);
			end else begin
				got_want = expected_beats.pop_front();
				if (m_axis_tuser !== got_want.kind)
					flag_mismatch("kind", WORD_W'(m_axis_tuser), WORD_W'(got_want.kind));
				if (m_axis_tdata[WORD_W-1:0] !== got_want.value)
					flag_mismatch("value", m_axis_tdata[WORD_W-1:0], got_want.value);
				if (m_axis_tlast !== got_want.slast)
					flag_mismatch("string_last", WORD_W'(m_axis_tlast),
						WORD_W'(got_want.slast));
				if (m_axis_tdata[WORD_W] !== got_want.ok)
					flag_mismatch("success", WORD_W'(m_axis_tdata[WORD_W]),
						WORD_W'(got_want.ok));
			end
			beats_seen++;
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Directed table helpers
	// ------------------------------------------------------------------
	function automatic stim_row_t cfg_row(logic idx, logic [COUNT_W-1:0] d);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.cdata = d;
		return r;
	endfunction

	function automatic stim_row_t byte_row(logic [7:0] db, logic eoc);
		stim_row_t r;
		r = '0;
		r.db = db;
		r.eoc = eoc;
		return r;
	endfunction

	function automatic stim_row_t checked_row(logic [7:0] db, logic eoc, kind_t k,
			logic [WORD_W-1:0] v, logic ok);
		stim_row_t r;
		r = byte_row(db, eoc);
		r.typed = 1'b1;
		r.want = beat_of(k, v, 1'b0, ok);
		return r;
	endfunction

	// one random setting: pick type and count, then one or two chunks of
	// mostly well-formed data with the odd truncation or trailing noise
	task automatic run_phase();
		logic [TYPE_W-1:0]  t;
		logic [COUNT_W-1:0] n_cfg;
		logic [31:0]        len;
		logic [7:0]         chunk_q[$];
		int                 pick;
		int                 nvals;
		pick = $urandom_range(0, 15);
		if (pick < 14)
			t = TYPE_W'(pick % 6);
		else
			t = (pick == 14) ? TYPE_RSVD6 : TYPE_RSVD7;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			n_cfg = '0;
		else if (pick == 1)
			n_cfg = COUNT_MAX;
		else
			n_cfg = COUNT_W'($urandom_range(1, 5));
		drain();
		cfg_write(REG_VALUE_TYPE, COUNT_W'(t));
		cfg_write(REG_VALUE_COUNT, n_cfg);
		quiet = ($urandom_range(0, 3) == 0);
		repeat ($urandom_range(1, 2)) begin
			chunk_q.delete();
			nvals = (n_cfg == COUNT_MAX) ? int'($urandom_range(1, 3)) : int'(n_cfg);
			if ($urandom_range(0, 5) == 0)
				nvals++;
			case (t)
				TYPE_INT32, TYPE_FLOAT32:
					repeat (4 * nvals) chunk_q.insert(chunk_q.size(), 8'($urandom));
				TYPE_INT64, TYPE_FLOAT64:
					repeat (8 * nvals) chunk_q.insert(chunk_q.size(), 8'($urandom));
				TYPE_BOOL:
					repeat ((n_cfg == COUNT_MAX) ? nvals : (nvals + 7) / 8)
						chunk_q.insert(chunk_q.size(), 8'($urandom));
				TYPE_BYTES: begin
					repeat (nvals) begin
						// now and then a negative length
						if ($urandom_range(0, 11) == 0)
							len = $urandom | 32'h8000_0000;
						else
							len = $urandom_range(0, 4);
						for (int k = 0; k < 4; k++)
							chunk_q.insert(chunk_q.size(), len[8 * k +: 8]);
						if (!len[31])
							repeat (len) chunk_q.insert(chunk_q.size(), 8'($urandom));
					end
				end
				default:
					repeat ($urandom_range(1, 6)) chunk_q.insert(chunk_q.size(), 8'($urandom));
			endcase
			if (chunk_q.size() > 1 && $urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, chunk_q.size() - 1)) void'(chunk_q.pop_back());
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) chunk_q.insert(chunk_q.size(), 8'($urandom));
			if (chunk_q.size() == 0)
				chunk_q.insert(chunk_q.size(), 8'($urandom));
			foreach (chunk_q[k])
				send_byte(chunk_q[k], k == chunk_q.size() - 1, 1'b0, '0);
		end
		quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int        target;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// out of reset: int32, count 0 -> nothing owed, good status
		add_row(checked_row(8'hA5, 1'b1, KIND_STATUS, '0, 1'b1));
		// all-ones int32, then a byte past the count is swallowed
		add_row(cfg_row(REG_VALUE_TYPE, COUNT_W'(TYPE_INT32)));
		add_row(cfg_row(REG_VALUE_COUNT, COUNT_W'(1)));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(byte_row(8'hFF, 1'b0));
		add_row(checked_row(8'hFF, 1'b0, KIND_FIXED, 64'h0000_0000_FFFF_FFFF, 1'b0));
		add_row(checked_row(8'h00, 1'b1, KIND_STATUS, '0, 1'b1));
		// byte arrays: empty value, then a string cut off by chunk end
		add_row(cfg_row(REG_VALUE_TYPE, COUNT_W'(TYPE_BYTES)));
		add_row(cfg_row(REG_VALUE_COUNT, COUNT_W'(2)));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(checked_row(8'h00, 1'b0, KIND_EMPTY, '0, 1'b0));
		add_row(byte_row(8'h02, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(checked_row(8'h7E, 1'b1, KIND_STATUS, '0, 1'b0));
		// negative length halts the chunk
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h00, 1'b0));
		add_row(byte_row(8'h80, 1'b0));
		add_row(checked_row(8'h11, 1'b1, KIND_STATUS, '0, 1'b0));
		// boolean tail: three of eight bits, then status on the same byte
		add_row(cfg_row(REG_VALUE_TYPE, COUNT_W'(TYPE_BOOL)));
		add_row(cfg_row(REG_VALUE_COUNT, COUNT_W'(3)));
		add_row(checked_row(8'hFF, 1'b1, KIND_STATUS, '0, 1'b1));
		// count lowered below the values done mid-chunk
		add_row(cfg_row(REG_VALUE_COUNT, COUNT_W'(9)));
		add_row(byte_row(8'hAA, 1'b0));
		add_row(cfg_row(REG_VALUE_COUNT, COUNT_W'(3)));
		add_row(checked_row(8'h55, 1'b1, KIND_STATUS, '0, 1'b0));
		// undefined type decodes nothing
		add_row(cfg_row(REG_VALUE_TYPE, COUNT_W'(TYPE_RSVD7)));
		add_row(checked_row(8'h12, 1'b1, KIND_STATUS, '0, 1'b0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				cfg_write(rows[i].idx, rows[i].cdata);
			end else begin
				send_byte(rows[i].db, rows[i].eoc, rows[i].typed, rows[i].want);
			end
		end

		target = items_sent + RANDOM_ITEMS;

		// back-pressure: booleans at full count make eight beats per byte; the
		// receiver stalls for a long stretch while bytes keep coming
		drain();
		cfg_write(REG_VALUE_TYPE, COUNT_W'(TYPE_BOOL));
		cfg_write(REG_VALUE_COUNT, COUNT_MAX);
		quiet = 1'b1;
		hold_item = items_sent + 1;
		repeat (11) send_byte(8'($urandom), 1'b0, 1'b0, '0);
		send_byte(8'($urandom), 1'b1, 1'b0, '0);
		quiet = 1'b0;
		hold_item = -1;

		while (items_sent < target)
			run_phase();

		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
